FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the calendar conversion block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/s2c_pkg.sv
// ----------------------------------------------------------------------------
// s2c_pkg
// Constants and calendar tables for the seconds to calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package s2c_pkg;

	localparam int YEAR_COUNT = 137;          // 1970 .. 2106
	localparam int MONTH_COUNT = 12;
	localparam logic [11:0] BASE_YEAR = 12'd1970;

	localparam logic [16:0] DAY_SECS  = 17'd86400;
	localparam logic [11:0] HOUR_SECS = 12'd3600;
	localparam logic [5:0]  MIN_SECS  = 6'd60;

	// Reciprocals for constant division, exact over the input range
	localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // (x >> 7) / 675, shift 35
	localparam logic [15:0] YEAR_RECIP = 16'd45965;     // x / 365, shift 24
	localparam logic [16:0] WEEK_RECIP = 17'd74899;     // x / 7, shift 19
	localparam logic [12:0] HOUR_RECIP = 13'd4661;      // (x >> 4) / 225, shift 20
	localparam logic [10:0] MIN_RECIP  = 11'd1093;      // (x >> 2) / 15, shift 14

	localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;      // 1970-01-01 was a Thursday

	typedef logic [15:0] ystart_tab_t [YEAR_COUNT];
	typedef logic [YEAR_COUNT-1:0] leap_tab_t;
	typedef logic [8:0] mstart_tab_t [MONTH_COUNT];

	// Day of year on which each month starts, common year
	localparam mstart_tab_t MONTH_START = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// Day count at which each year starts; leap rule tracked by running counters
	function automatic ystart_tab_t build_year_start();
		ystart_tab_t tab;
		logic [15:0] acc;
		int m4;
		int m100;
		int m400;
		logic lp;
		acc = 16'd0;
		m4 = 2;
		m100 = 70;
		m400 = 370;
		for (int i = 0; i < YEAR_COUNT; i++) begin
			tab[i] = acc;
			lp = (m4 == 0) && ((m100 != 0) || (m400 == 0));
			acc = acc + (lp ? 16'd366 : 16'd365);
			m4 = (m4 == 3) ? 0 : m4 + 1;
			m100 = (m100 == 99) ? 0 : m100 + 1;
			m400 = (m400 == 399) ? 0 : m400 + 1;
		end
		return tab;
	endfunction

	function automatic leap_tab_t build_leap();
		leap_tab_t tab;
		int m4;
		int m100;
		int m400;
		m4 = 2;
		m100 = 70;
		m400 = 370;
		for (int i = 0; i < YEAR_COUNT; i++) begin
			tab[i] = (m4 == 0) && ((m100 != 0) || (m400 == 0));
			m4 = (m4 == 3) ? 0 : m4 + 1;
			m100 = (m100 == 99) ? 0 : m100 + 1;
			m400 = (m400 == 399) ? 0 : m400 + 1;
		end
		return tab;
	endfunction

	localparam ystart_tab_t YEAR_START = build_year_start();
	localparam leap_tab_t YEAR_LEAP = build_leap();

endpackage

`default_nettype wire

FILE: design/seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// seconds_to_calendar
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian date, time of day and weekday.
// ----------------------------------------------------------------------------
// Seven-stage pipeline: each input is registered through stages 1 to 7 in turn,
// and a new input is taken every cycle unless all stages are full and the output stalls.
// The depth is set by the chain of constant-reciprocal multiplies (days, then
// time of day into hours, minutes and seconds), each followed by a register.
// The year is found by estimating days / 365 and correcting once against a
// table of year start days; the month by comparing the day of year against
// the month start table. A stage holds only while the stage after it is full
// and held, so empty stages fill even while a result waits at the output.
`default_nettype none

`include "assert_macros.svh"

module seconds_to_calendar (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] seconds_count
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
	// [31:26] minute, [37:32] second, [40:38] weekday, [47:41] zero
	output logic [47:0]      m_axis_tdata
);

	import s2c_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	// Stage registers
	logic [31:0] secs_s1, secs_s2;
	logic [50:0] dprod_s1;
	logic [15:0] days_s2, days_s3;
	logic [16:0] tod_s3, tod_s4;
	logic [7:0]  est_s3;
	logic [15:0] wkx_s3;
	logic [13:0] wkq_s3;
	logic [4:0]  hour_s4, hour_s5, hour_s6, hour_s7;
	logic [11:0] year_s4, year_s5, year_s6, year_s7;
	logic        leap_s4;
	logic [8:0]  doy_s4, doy_s5;
	logic [2:0]  wd_s4, wd_s5, wd_s6, wd_s7;
	logic [11:0] rest_s5, rest_s6;
	logic [3:0]  month_s5, month_s6, month_s7;
	logic [8:0]  dstart_s5;
	logic [5:0]  minute_s6, minute_s7;
	logic [4:0]  day_s6, day_s7;
	logic [5:0]  second_s7;

	// Combinational results per stage
	logic [31:0] tod_full;
	logic [31:0] est_prod;
	logic [15:0] wk_x;
	logic [32:0] wk_prod;
	logic [25:0] hour_prod;
	logic [16:0] yr_diff;
	logic        yr_neg;
	logic [7:0]  prev_idx;
	logic [7:0]  yr_idx;
	logic [15:0] yr_start;
	logic [15:0] wd_full;
	logic [11:0] rest_full;
	logic [3:0]  mon_idx;
	logic [8:0]  mon_start;
	logic [8:0]  mon_thr;
	logic [20:0] min_prod;
	logic [8:0]  day_full;

	// Backpressure: a stage advances when it is empty or the next one advances
	assign en_s7 = !vld_s7 || m_axis_tready;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= s_axis_tvalid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
		end
	end

	// Stage 1: seconds / 86400 as (seconds >> 7) * reciprocal of 675
	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			secs_s1  <= s_axis_tdata;
			dprod_s1 <= 51'(s_axis_tdata[31:7]) * 51'(DAY_RECIP);
		end
	end

	// Stage 2: take the day count
	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			secs_s2 <= secs_s1;
			days_s2 <= dprod_s1[50:35];
		end
	end

	// Stage 3: time of day, year estimate, weekday quotient
	assign tod_full = secs_s2 - (32'(days_s2) * 32'(DAY_SECS));
	assign est_prod = 32'(days_s2) * 32'(YEAR_RECIP);
	assign wk_x     = days_s2 + EPOCH_WEEKDAY;
	assign wk_prod  = 33'(wk_x) * 33'(WEEK_RECIP);

	always_ff @(posedge clk) begin
		if (en_s3 && vld_s2) begin
			tod_s3  <= tod_full[16:0];
			days_s3 <= days_s2;
			est_s3  <= est_prod[31:24];
			wkx_s3  <= wk_x;
			wkq_s3  <= wk_prod[32:19];
		end
	end

	// Stage 4: correct the year estimate by one, day of year, hour, weekday
	always_comb begin
		yr_start = YEAR_START[est_s3];
		yr_diff  = {1'b0, days_s3} - {1'b0, yr_start};
		yr_neg   = yr_diff[16];
		prev_idx = (est_s3 == 8'd0) ? 8'd0 : est_s3 - 8'd1;
		yr_idx   = yr_neg ? prev_idx : est_s3;
	end

	assign hour_prod = 26'(tod_s3[16:4]) * 26'(HOUR_RECIP);
	assign wd_full   = wkx_s3 - (16'(wkq_s3) * 16'd7);

	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			tod_s4  <= tod_s3;
			hour_s4 <= hour_prod[24:20];
			year_s4 <= BASE_YEAR + 12'(yr_idx);
			leap_s4 <= YEAR_LEAP[yr_idx];
			doy_s4  <= yr_neg ? 9'(days_s3 - YEAR_START[prev_idx]) : yr_diff[8:0];
			wd_s4   <= wd_full[2:0];
		end
	end

	// Stage 5: month by threshold compare, seconds within the hour
	always_comb begin
		mon_idx   = 4'd0;
		mon_start = 9'd0;
		mon_thr   = 9'd0;
		for (int i = 1; i < MONTH_COUNT; i++) begin
			// shift every month after February by the leap day
			mon_thr = MONTH_START[i] + ((i >= 2) ? 9'(leap_s4) : 9'd0);
			if (doy_s4 >= mon_thr) begin
				mon_idx   = 4'(i);
				mon_start = mon_thr;
			end
		end
	end

	assign rest_full = tod_s4[11:0] - (12'(hour_s4) * HOUR_SECS);

	always_ff @(posedge clk) begin
		if (en_s5 && vld_s4) begin
			rest_s5   <= rest_full;
			hour_s5   <= hour_s4;
			year_s5   <= year_s4;
			month_s5  <= mon_idx + 4'd1;
			doy_s5    <= doy_s4;
			dstart_s5 <= mon_start;
			wd_s5     <= wd_s4;
		end
	end

	// Stage 6: minute, day of month
	assign min_prod = 21'(rest_s5[11:2]) * 21'(MIN_RECIP);
	assign day_full = doy_s5 - dstart_s5 + 9'd1;

	always_ff @(posedge clk) begin
		if (en_s6 && vld_s5) begin
			rest_s6   <= rest_s5;
			minute_s6 <= min_prod[19:14];
			hour_s6   <= hour_s5;
			year_s6   <= year_s5;
			month_s6  <= month_s5;
			day_s6    <= day_full[4:0];
			wd_s6     <= wd_s5;
		end
	end

	// Stage 7: second, output register
	always_ff @(posedge clk) begin
		if (en_s7 && vld_s6) begin
			second_s7 <= 6'(rest_s6 - (12'(minute_s6) * 12'(MIN_SECS)));
			minute_s7 <= minute_s6;
			hour_s7   <= hour_s6;
			year_s7   <= year_s6;
			month_s7  <= month_s6;
			day_s7    <= day_s6;
			wd_s7     <= wd_s6;
		end
	end

	assign m_axis_tvalid = vld_s7;
	assign m_axis_tdata  = {7'd0, wd_s7, second_s7, minute_s7, hour_s7, day_s7,
		month_s7, year_s7};

	`ASSERT_IMPLY(a_date_range, clk, arst_n, vld_s7,
		(month_s7 >= 4'd1 && month_s7 <= 4'd12 && day_s7 >= 5'd1 && day_s7 <= 5'd31 &&
		year_s7 >= 12'd1970 && year_s7 <= 12'd2106),
		"calendar date out of range")
	`ASSERT_IMPLY(a_time_range, clk, arst_n, vld_s7,
		(hour_s7 < 5'd24 && minute_s7 < 6'd60 && second_s7 < 6'd60 && wd_s7 < 3'd7),
		"time of day or weekday out of range")
	`ASSERT_IMPLY(a_feb_len, clk, arst_n, (vld_s7 && month_s7 == 4'd2),
		(day_s7 <= 5'd29), "February longer than 29 days")
	`ASSERT_IMPLY(a_year_fix, clk, arst_n, (vld_s3 && yr_neg),
		(est_s3 != 8'd0), "year estimate corrected below the first year")

endmodule

`default_nettype wire
